// ===== rtl/lc3_pkg.sv =====
// LC-3 executor package: beat structs, opcode and command codes, state encoding.
// No dependencies.
package lc3_pkg;

  localparam int unsigned MemoryWordsDef = 65536;

  localparam logic [15:0] AddrDsr  = 16'hFE04;
  localparam logic [15:0] AddrDdr  = 16'hFE06;
  localparam logic [15:0] AddrMcr  = 16'hFFFE;
  localparam logic [15:0] ReadyBit = 16'h8000;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SETPC = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_BR   = 4'd0,
    OP_ADD  = 4'd1,
    OP_LD   = 4'd2,
    OP_ST   = 4'd3,
    OP_JSR  = 4'd4,
    OP_AND  = 4'd5,
    OP_LDR  = 4'd6,
    OP_STR  = 4'd7,
    OP_RTI  = 4'd8,
    OP_NOT  = 4'd9,
    OP_LDI  = 4'd10,
    OP_STI  = 4'd11,
    OP_RET  = 4'd12,
    OP_RES  = 4'd13,
    OP_LEA  = 4'd14,
    OP_TRAP = 4'd15
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC,
    ST_RF2,
    ST_EXEC,
    ST_MEM1,
    ST_IND,
    ST_MEM2,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [15:0] word_in;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] pc_out;
    logic        executed;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        halted;
    logic        fault;
  } out_beat_t;

  // n/z/p from the sign of a result
  function automatic logic [2:0] cc_of(logic [15:0] v);
    logic [2:0] r;
    if (v[15]) r = 3'b100;
    else if (v == 16'h0000) r = 3'b010;
    else r = 3'b001;
    return r;
  endfunction

  function automatic logic is_io(logic [15:0] a);
    return (a == AddrDsr) || (a == AddrDdr) || (a == AddrMcr);
  endfunction

endpackage

// ===== rtl/lc3_instruction_executor.sv =====
// LC-3 executor top level: command sequencer around main memory and register file RAMs.
// Depends on lc3_pkg and lc3_ram.
// Sequence: write, set, ignored and stopped-execute items go from IDLE straight to FIN;
//   an execute goes IDLE, DEC, RF2, EXEC, then MEM1 for TRAP and for LD/LDR/LDI/STI on a
//   memory address, IND for LDI/STI, and MEM2 for an LDI whose pointer is not I/O, then FIN.
// No new item is taken until the current one leaves FIN, which waits for a free output slot.
// Reset: asynchronous; afterwards a pass zeroes every main memory word, and no beat is
//   accepted during it. Register file reads as zero until written.
module lc3_instruction_executor
  import lc3_pkg::*;
#(
  parameter int unsigned MEMORY_WORDS = MemoryWordsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned Aw = $clog2(MEMORY_WORDS);

  state_e state_q, state_d;

  // architectural registers
  logic [15:0] pc_q, pc_d;
  logic [2:0]  cc_q, cc_d;
  logic [15:0] mcr_q, mcr_d, dsr_q, dsr_d, ddr_q, ddr_d;
  logic        fault_q, fault_d;
  logic [7:0]  rf_vld_q, rf_vld_d;

  // per-item working registers
  logic [15:0] ir_q, ir_d, a_q, a_d, b_q, b_d, addr_q, addr_d;
  logic        exec_q, exec_d, chv_q, chv_d;
  logic [7:0]  ch_q, ch_d;
  logic [Aw-1:0] clr_q, clr_d;
  logic [2:0]  rf_ra_q;

  out_beat_t out_q, out_d;
  logic      out_vld_q, out_vld_d;

  // RAM ports
  logic          mem_we;
  logic [Aw-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd, mem_rd;
  logic          rf_we;
  logic [2:0]    rf_wa, rf_ra;
  logic [15:0]   rf_wd, rf_rdata, rf_rd;

  lc3_ram #(.Width(16), .Depth(MEMORY_WORDS)) u_main_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_wa), .wdata_i(mem_wd),
    .raddr_i(mem_ra), .rdata_o(mem_rd)
  );

  lc3_ram #(.Width(16), .Depth(8)) u_regfile (
    .clk_i, .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd),
    .raddr_i(rf_ra), .rdata_o(rf_rdata)
  );

  // a never-written register reads as zero
  assign rf_rd = rf_vld_q[rf_ra_q] ? rf_rdata : 16'h0000;

  // decode of the latched instruction
  op_e         op;
  logic [2:0]  r1, r2, r3;
  logic [15:0] off9, off6, imm5, off11, ea, alu_b;
  logic        running, acc, slot_free;

  assign op      = op_e'(ir_q[15:12]);
  assign r1      = ir_q[11:9];
  assign r2      = ir_q[8:6];
  assign r3      = ir_q[2:0];
  assign off9    = {{7{ir_q[8]}}, ir_q[8:0]};
  assign off6    = {{10{ir_q[5]}}, ir_q[5:0]};
  assign imm5    = {{11{ir_q[4]}}, ir_q[4:0]};
  assign off11   = {{5{ir_q[10]}}, ir_q[10:0]};
  assign ea      = (op == OP_LDR || op == OP_STR) ? a_q + off6 : pc_q + off9;
  assign alu_b   = ir_q[5] ? imm5 : rf_rd;
  assign running = mcr_q[15] && !fault_q;
  assign acc     = in_valid_i && !in_stall_o;
  assign slot_free = !out_vld_q || !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // routed register read
  function automatic logic [15:0] io_rd(logic [15:0] a, logic [15:0] dsr,
                                        logic [15:0] ddr, logic [15:0] mcr);
    logic [15:0] r;
    if (a == AddrDsr) r = dsr;
    else if (a == AddrDdr) r = ddr;
    else r = mcr;
    return r;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == Aw'(MEMORY_WORDS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (acc) begin
          state_d = (cmd_e'(in_data_i.cmd) == CMD_EXEC && running) ? ST_DEC : ST_FIN;
        end
      end
      ST_DEC: state_d = ST_RF2;
      ST_RF2: state_d = ST_EXEC;
      ST_EXEC: begin
        case (op)
          OP_TRAP:        state_d = ST_MEM1;
          OP_LD, OP_LDR:  state_d = is_io(ea) ? ST_FIN : ST_MEM1;
          OP_LDI, OP_STI: state_d = is_io(ea) ? ST_IND : ST_MEM1;
          default:        state_d = ST_FIN;
        endcase
      end
      ST_MEM1: state_d = (op == OP_LDI || op == OP_STI) ? ST_IND : ST_FIN;
      ST_IND:  state_d = (op == OP_LDI && !is_io(addr_q)) ? ST_MEM2 : ST_FIN;
      ST_MEM2: state_d = ST_FIN;
      ST_FIN:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    logic [15:0] wv, wa;
    logic        bus_we, load_we;
    logic [15:0] load_v;
    pc_d = pc_q; cc_d = cc_q; mcr_d = mcr_q; dsr_d = dsr_q; ddr_d = ddr_q;
    fault_d = fault_q; rf_vld_d = rf_vld_q;
    ir_d = ir_q; a_d = a_q; b_d = b_q; addr_d = addr_q;
    exec_d = exec_q; chv_d = chv_q; ch_d = ch_q; clr_d = clr_q;
    out_d = out_q; out_vld_d = out_vld_q;
    mem_we = 1'b0; mem_wa = clr_q; mem_wd = 16'h0000; mem_ra = pc_q[Aw-1:0];
    rf_we = 1'b0; rf_wa = r1; rf_wd = 16'h0000; rf_ra = r2;
    wv = b_q; wa = ea; bus_we = 1'b0; load_we = 1'b0; load_v = 16'h0000;

    if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (acc) begin
          exec_d = 1'b0;
          chv_d  = 1'b0;
          ch_d   = 8'h00;
          case (cmd_e'(in_data_i.cmd))
            CMD_WRITE: begin
              mem_we = 1'b1;
              mem_wa = in_data_i.address[Aw-1:0];
              mem_wd = in_data_i.word_in;
            end
            CMD_SETPC: pc_d = in_data_i.address;
            CMD_EXEC: begin
              if (running) begin
                // display service, then fetch
                if (dsr_q == 16'h0000) begin
                  chv_d = 1'b1;
                  ch_d  = ddr_q[7:0];
                  dsr_d = ReadyBit;
                end
                pc_d = pc_q + 16'd1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DEC: begin
        ir_d  = mem_rd;
        rf_ra = (op_e'(mem_rd[15:12]) == OP_RET) ? 3'd7 : mem_rd[8:6];
      end
      ST_RF2: begin
        a_d   = rf_rd;
        rf_ra = (op == OP_ADD || op == OP_AND) ? r3 : r1;
      end
      ST_EXEC: begin
        b_d    = rf_rd;
        wv     = rf_rd;
        exec_d = 1'b1;
        mem_ra = ea[Aw-1:0];
        case (op)
          OP_ADD: begin load_we = 1'b1; load_v = a_q + alu_b; end
          OP_AND: begin load_we = 1'b1; load_v = a_q & alu_b; end
          OP_NOT: begin load_we = 1'b1; load_v = ~a_q; end
          OP_LEA: begin load_we = 1'b1; load_v = ea; end
          OP_BR:  if ((r1 & cc_q) != 3'b000) pc_d = ea;
          OP_JSR: begin
            rf_we = 1'b1; rf_wa = 3'd7; rf_wd = pc_q;
            pc_d  = pc_q + off11;
          end
          OP_RET: pc_d = a_q;
          OP_TRAP: begin
            rf_we  = 1'b1; rf_wa = 3'd7; rf_wd = pc_q;
            mem_ra = Aw'(ir_q[7:0]);
          end
          OP_LD, OP_LDR: begin
            if (is_io(ea)) begin
              load_we = 1'b1; load_v = io_rd(ea, dsr_q, ddr_q, mcr_q);
            end
          end
          OP_LDI, OP_STI: if (is_io(ea)) addr_d = io_rd(ea, dsr_q, ddr_q, mcr_q);
          OP_ST, OP_STR: bus_we = 1'b1;
          default: begin
            exec_d  = 1'b0;
            fault_d = 1'b1;
          end
        endcase
      end
      ST_MEM1: begin
        case (op)
          OP_TRAP: pc_d = mem_rd;
          OP_LD, OP_LDR: begin load_we = 1'b1; load_v = mem_rd; end
          default: addr_d = mem_rd;
        endcase
      end
      ST_IND: begin
        mem_ra = addr_q[Aw-1:0];
        wa     = addr_q;
        if (op == OP_STI) bus_we = 1'b1;
        else if (is_io(addr_q)) begin
          load_we = 1'b1; load_v = io_rd(addr_q, dsr_q, ddr_q, mcr_q);
        end
      end
      ST_MEM2: begin
        load_we = 1'b1; load_v = mem_rd;
      end
      ST_FIN: begin
        if (slot_free) begin
          out_vld_d        = 1'b1;
          out_d.pc_out     = pc_q;
          out_d.executed   = exec_q;
          out_d.char_valid = chv_q;
          out_d.char_out   = ch_q;
          out_d.halted     = !mcr_q[15];
          out_d.fault      = fault_q;
        end
      end
      default: ;
    endcase

    if (load_we) begin
      rf_we = 1'b1; rf_wa = r1; rf_wd = load_v;
      cc_d  = cc_of(load_v);
    end
    if (rf_we) rf_vld_d[rf_wa] = 1'b1;

    if (bus_we) begin
      if (wa == AddrDsr) dsr_d = wv;
      else if (wa == AddrDdr) begin
        ddr_d = wv;
        dsr_d = 16'h0000;
      end else if (wa == AddrMcr) mcr_d = wv;
      else begin
        mem_we = 1'b1; mem_wa = wa[Aw-1:0]; mem_wd = wv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      pc_q      <= 16'h0000;
      cc_q      <= 3'b010;
      mcr_q     <= ReadyBit;
      dsr_q     <= ReadyBit;
      ddr_q     <= 16'h0000;
      fault_q   <= 1'b0;
      rf_vld_q  <= 8'h00;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      exec_q    <= 1'b0;
      chv_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      cc_q      <= cc_d;
      mcr_q     <= mcr_d;
      dsr_q     <= dsr_d;
      ddr_q     <= ddr_d;
      fault_q   <= fault_d;
      rf_vld_q  <= rf_vld_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      exec_q    <= exec_d;
      chv_q     <= chv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q    <= ir_d;
    a_q     <= a_d;
    b_q     <= b_d;
    addr_q  <= addr_d;
    ch_q    <= ch_d;
    out_q   <= out_d;
    rf_ra_q <= rf_ra;
  end

endmodule

// ===== rtl/lc3_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lc3_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for lc3_instruction_executor: directed programs, then random
// instruction streams, checked against an in-bench LC-3 behavioural predictor.
// Depends on lc3_pkg and the executor RTL.
module tb_top
  import lc3_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Predictor of the executor: architectural state and one-beat behaviour.
  class lc3_scoreboard;
    logic [15:0] mem [0:65535];
    logic [15:0] regs [0:7];
    logic [15:0] pc, mcr, dsr, ddr;
    logic [2:0]  nzp;
    logic        faulted;
    out_beat_t   pending [$];
    int          errors, checked, n_exec, n_chars, n_in;

    function new();
      for (int i = 0; i < 65536; i++) mem[i] = 16'h0000;
      for (int i = 0; i < 8; i++) regs[i] = 16'h0000;
      pc = 16'h0000; mcr = ReadyBit; dsr = ReadyBit; ddr = 16'h0000;
      nzp = 3'b010; faulted = 1'b0;
    endfunction

    function logic [15:0] sx(logic [15:0] v, int bits);
      logic [15:0] r;
      r = v;
      for (int i = bits; i < 16; i++) r[i] = v[bits-1];
      return r;
    endfunction

    function logic [2:0] flags(logic [15:0] v);
      if (v[15]) return 3'b100;
      if (v == 16'h0000) return 3'b010;
      return 3'b001;
    endfunction

    function logic [15:0] rd(logic [15:0] a);
      if (a == AddrDsr) return dsr;
      if (a == AddrDdr) return ddr;
      if (a == AddrMcr) return mcr;
      return mem[a];
    endfunction

    function void wr(logic [15:0] a, logic [15:0] v);
      if (a == AddrDsr) dsr = v;
      else if (a == AddrDdr) begin
        ddr = v; dsr = 16'h0000;
      end else if (a == AddrMcr) mcr = v;
      else mem[a] = v;
    endfunction

    function void wreg(logic [2:0] r, logic [15:0] v);
      regs[r] = v; nzp = flags(v);
    endfunction

    // true when the opcode is one the block knows
    function bit run_insn(logic [15:0] ir);
      op_e op;
      logic [2:0] dr, sr1;
      logic [15:0] b, t, p9;
      op = op_e'(ir[15:12]);
      dr = ir[11:9]; sr1 = ir[8:6];
      p9 = pc + sx(ir, 9);
      b = ir[5] ? sx(ir, 5) : regs[ir[2:0]];
      case (op)
        OP_ADD: wreg(dr, regs[sr1] + b);
        OP_AND: wreg(dr, regs[sr1] & b);
        OP_NOT: wreg(dr, ~regs[sr1]);
        OP_BR:  if ((dr & nzp) != 3'b000) pc = p9;
        OP_LD:  wreg(dr, rd(p9));
        OP_LDI: begin
          t = rd(p9); wreg(dr, rd(t));
        end
        OP_LDR: wreg(dr, rd(regs[sr1] + sx(ir, 6)));
        OP_ST:  wr(p9, regs[dr]);
        OP_STI: begin
          t = rd(p9); wr(t, regs[dr]);
        end
        OP_STR: wr(regs[sr1] + sx(ir, 6), regs[dr]);
        OP_LEA: wreg(dr, p9);
        OP_JSR: begin
          t = pc; regs[7] = t; pc = t + sx(ir, 11);
        end
        OP_RET: pc = regs[7];
        OP_TRAP: begin
          regs[7] = pc; pc = mem[{8'h00, ir[7:0]}];
        end
        default: return 0;
      endcase
      return 1;
    endfunction

    // note an accepted input beat and queue what it should produce
    function void note_input(in_beat_t b);
      out_beat_t e;
      e = '0;
      n_in++;
      case (cmd_e'(b.cmd))
        CMD_WRITE: mem[b.address] = b.word_in;
        CMD_SETPC: pc = b.address;
        CMD_EXEC: if (mcr[15] && !faulted) begin
          logic [15:0] ir;
          if (dsr == 16'h0000) begin
            e.char_valid = 1'b1; e.char_out = ddr[7:0]; dsr = ReadyBit; n_chars++;
          end
          ir = mem[pc];
          pc = pc + 16'd1;
          if (run_insn(ir)) begin
            e.executed = 1'b1; n_exec++;
          end else faulted = 1'b1;
        end
        default: ;
      endcase
      e.pc_out = pc; e.halted = !mcr[15]; e.fault = faulted;
      pending.push_back(e);
    endfunction

    function void check_result(out_beat_t a);
      out_beat_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.pc_out !== e.pc_out) begin
        $error("pc_out exp %h got %h", e.pc_out, a.pc_out); errors++;
      end
      if (a.executed !== e.executed) begin
        $error("executed exp %b got %b", e.executed, a.executed); errors++;
      end
      if (a.char_valid !== e.char_valid) begin
        $error("char_valid exp %b got %b", e.char_valid, a.char_valid); errors++;
      end
      if (a.char_out !== e.char_out) begin
        $error("char_out exp %h got %h", e.char_out, a.char_out); errors++;
      end
      if (a.halted !== e.halted) begin
        $error("halted exp %b got %b", e.halted, a.halted); errors++;
      end
      if (a.fault !== e.fault) begin
        $error("fault exp %b got %b", e.fault, a.fault); errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  lc3_scoreboard sb;
  bit  idle_on = 1'b1;      // random gaps on both sides
  bit  hold_out = 1'b0;     // long receiver hold-off
  longint cycles = 0;
  localparam longint CycleLimit = 3_000_000;
  localparam int ItemTarget = 1480;
  localparam int CalmFrom = 1200;

  always #2 clk_i = ~clk_i;

  lc3_instruction_executor u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // sample at rising edge: accepted result beats
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // receiver stall: bursts, plus the long hold-off when asked
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_out) out_stall_i <= 1'b1;
      else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= hold_out;
      end else out_stall_i <= 1'b0;
    end
  end

  // offer one beat; held until accepted
  task automatic send(cmd_e c, logic [15:0] a, logic [15:0] w);
    in_beat_t b;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    b.cmd = c; b.address = a; b.word_in = w;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(b);
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  task automatic poke(logic [15:0] a, logic [15:0] w);
    send(CMD_WRITE, a, w);
  endtask

  task automatic step();
    send(CMD_EXEC, 16'($urandom()), 16'($urandom()));
  endtask

  // mostly valid opcodes; BR and JSR get a small forward offset half of the time
  function automatic logic [15:0] rand_insn();
    logic [15:0] ir;
    int k;
    ir = 16'($urandom());
    k = $urandom_range(0, 99);
    if (k < 3) ir[15:12] = OP_RTI;
    else if (k < 5) ir[15:12] = OP_RES;
    else begin
      while (ir[15:12] == OP_RTI || ir[15:12] == OP_RES) ir[15:12] = 4'($urandom());
    end
    if (ir[15:12] == OP_BR && $urandom_range(0, 1)) ir[8:0] = 9'($urandom_range(0, 3));
    if (ir[15:12] == OP_JSR && $urandom_range(0, 1)) ir[10:0] = 11'($urandom_range(0, 4));
    return ir;
  endfunction

  // a short program of random instructions at a random base, then run it
  task automatic run_block(int len);
    logic [15:0] base;
    base = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(16'h3000, 16'h3040));
    for (int i = 0; i < len; i++) poke(base + 16'(i), rand_insn());
    for (int i = 0; i < 8; i++) poke(base + 16'(len + i), rand_insn());
    send(CMD_SETPC, base, 16'($urandom()));
    for (int i = 0; i < len; i++) step();
  endtask

  initial begin
    int blk;
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: ALU with extreme immediates, TRAP via vector table, display I/O
    idle_on = 1'b0;
    poke(16'h0025, 16'h3010);                 // trap vector
    poke(16'h3000, 16'h103F);                 // ADD R0,R0,#-1
    poke(16'h3001, 16'h522F);                 // AND R1,R0,#15
    poke(16'h3002, 16'h947F);                 // NOT R2,R1
    poke(16'h3003, 16'hE7FF);                 // LEA R3,#-1
    poke(16'h3004, 16'h0E01);                 // BRnzp +1
    poke(16'h3006, 16'h2A05);                 // LD R5, [3006+1+5] = ddr ptr
    poke(16'h300C, AddrDdr);
    poke(16'h3007, 16'hB204);                 // STI R1 -> *[300C] = DDR
    poke(16'h3008, 16'hA804);                 // LDI R4 via 300D -> DSR
    poke(16'h300D, AddrDsr);
    poke(16'h3009, 16'h6D41);                 // LDR R6,R5,#1
    poke(16'h300A, 16'h7141);                 // STR R0,R5,#1
    poke(16'h300B, 16'hF025);                 // TRAP x25
    poke(16'h3010, 16'hC1C0);                 // RET
    poke(16'hFFFF, 16'h4FFF);                 // JSR -1 at top of memory
    send(CMD_SETPC, 16'h3000, 16'h0000);
    repeat (12) step();
    send(CMD_NONE, 16'hFFFF, 16'hFFFF);
    send(CMD_SETPC, 16'hFFFF, 16'h0000);
    step();

    // random programs, with a long receiver hold-off part way through
    idle_on = 1'b1;
    blk = 0;
    while (sb.n_in < ItemTarget) begin
      if (blk == 20) begin
        fork
          begin
            hold_out = 1'b1;
            repeat (400) @(negedge clk_i);
            hold_out = 1'b0;
          end
        join_none
      end
      if (sb.n_in >= CalmFrom) idle_on = 1'b0;
      if (sb.faulted || !sb.mcr[15]) begin
        // sticky stop: keep exercising writes, sets and ignored items
        send(cmd_e'(2'($urandom_range(0, 3))), 16'($urandom()), 16'($urandom()));
        poke(AddrMcr, 16'($urandom()));
        poke(AddrDdr, 16'($urandom()));
        send(CMD_SETPC, 16'h0000, 16'h0000);
        repeat (3) step();
      end else run_block($urandom_range(6, 14));
      blk++;
    end
    // final store of R0 to the machine control register
    if (!sb.faulted && sb.mcr[15]) begin
      poke(16'h4000, 16'h3001);               // ST R0 -> [4002]
      poke(16'h4002, AddrMcr);
      poke(16'h4001, 16'hB000);               // STI R0 via [4002]
      send(CMD_SETPC, 16'h4001, 16'h0000);
      step();
      step();
    end
    drop_valid();

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("checked %0d results: %0d instructions executed, %0d characters shown",
             sb.checked, sb.n_exec, sb.n_chars);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
